FILE: hdl/falling_sand_cell_update_core_assert.svh
// Assertion macros for the falling-sand cell update core.
`ifndef FALLING_SAND_CELL_UPDATE_CORE_ASSERT_SVH
`define FALLING_SAND_CELL_UPDATE_CORE_ASSERT_SVH
`define FS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hdl/fscu_pkg.sv
// Shared types and constants for the falling-sand cell update core.
package fscu_pkg;
   localparam int GridWidthDefault  = 256;
   localparam int GridHeightDefault = 256;
   localparam logic [2:0] SideReachReset = 3'd3;

   typedef enum logic [1:0] {
      CELL_EMPTY = 2'd0, CELL_SAND = 2'd1, CELL_FROZEN = 2'd2, CELL_WATER = 2'd3
   } cell_type;

   typedef enum logic [1:0] {
      ACT_UPDATE = 2'd0, ACT_PLACE_SAND = 2'd1, ACT_PLACE_WATER = 2'd2, ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OUT_SKIPPED = 3'd0, OUT_STAYED = 3'd1, OUT_MOVED = 3'd2, OUT_SWAPPED = 3'd3,
      OUT_FROZE = 3'd4, OUT_PLACED = 3'd5, OUT_REFUSED = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      KIND_SKIP = 2'd0, KIND_UPDATE = 2'd1, KIND_PLACE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      cell_type  place_cell;
      logic [7:0] x;
      logic [7:0] y;
      logic       right_first;
   } job_type;

   localparam logic [1:0] CsrSideReach = 2'd0;
endpackage

FILE: hdl/fscu_front.sv
// Front end: accepts items, classifies them and queues jobs.
module fscu_front #(
   parameter int GridWidth  = fscu_pkg::GridWidthDefault,
   parameter int GridHeight = fscu_pkg::GridHeightDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_action,
   input  logic [7:0]       req_cell_x,
   input  logic [7:0]       req_cell_y,
   input  logic             req_try_right_first,
   output logic             job_valid,
   input  logic             job_take,
   output fscu_pkg::job_type job
);
   import fscu_pkg::*;
   `include "falling_sand_cell_update_core_assert.svh"

   job_type    q_ff [2];
   job_type    q_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       in_grid, push, pop;

   assign in_grid = ({24'd0, req_cell_x} < GridWidth) && ({24'd0, req_cell_y} < GridHeight);
   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = job_valid && job_take;
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rp_ff];

   always_comb begin
      q_in = '0;
      q_in.x = req_cell_x;
      q_in.y = req_cell_y;
      q_in.right_first = req_try_right_first;
      q_in.kind = KIND_SKIP;
      q_in.place_cell = (req_action == ACT_PLACE_SAND) ? CELL_SAND : CELL_WATER;
      if (req_action == ACT_PLACE_SAND || req_action == ACT_PLACE_WATER) begin
         q_in.kind = KIND_PLACE;
      end else if (req_action == ACT_UPDATE && in_grid
                   && ({24'd0, req_cell_y} < GridHeight - 1)) begin
         q_in.kind = KIND_UPDATE;
      end
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= q_in;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   `FS_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3)
   `FS_ASSERT_IMP(a_ptr_cnt, clock, reset, cnt_ff != 2'd1, wp_ff == rp_ff)
   `FS_ASSERT_NXT(a_full_stall, clock, reset, cnt_ff == 2'd2 && !pop, req_stall)
endmodule

FILE: hdl/fscu_back.sv
// Back end: grid memory, clearing pass and per-job sequencer.
module fscu_back #(
   parameter int GridWidth  = fscu_pkg::GridWidthDefault,
   parameter int GridHeight = fscu_pkg::GridHeightDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        side_reach,
   input  logic              job_valid,
   output logic              job_take,
   input  fscu_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_outcome,
   output logic [7:0]        rsp_new_x,
   output logic [7:0]        rsp_new_y
);
   import fscu_pkg::*;
   `include "falling_sand_cell_update_core_assert.svh"

   localparam int Depth = GridWidth * GridHeight;
   localparam int AW = $clog2(Depth);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001, ST_IDLE = 8'b00000010, ST_READ = 8'b00000100,
      ST_WAIT = 8'b00001000, ST_EVAL = 8'b00010000, ST_WR1 = 8'b00100000,
      ST_WR2 = 8'b01000000, ST_OUT = 8'b10000000
   } state_type;

   cell_type mem [Depth];
   cell_type rd_ff;

   state_type  st_ff, st_in;
   logic [AW:0] clr_ff, clr_in;
   job_type    job_ff, job_in;
   cell_type   self_ff, self_in;
   logic [4:0] step_ff, step_in;
   logic       cand_ok;
   logic signed [13:0] tx, ty;
   logic [13:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [2:0] out_ff, out_in;
   cell_type   wv1_ff, wv1_in, wv2_ff, wv2_in;
   logic [7:0] ox_ff, ox_in, oy_ff, oy_in;
   logic       rv_ff, rv_in;
   logic       mwe;
   logic [AW-1:0] maddr, raddr;
   cell_type   mdat;
   logic [4:0] last_step;

   // candidate target for the current step
   always_comb begin
      tx = {6'd0, job_ff.x};
      ty = {6'd0, job_ff.y} + 14'sd1;
      if (step_ff == 5'd0) begin
         tx = {6'd0, job_ff.x};
         ty = {6'd0, job_ff.y};
      end else if (self_ff == CELL_SAND) begin
         unique case (step_ff)
            5'd2: tx = {6'd0, job_ff.x} + (job_ff.right_first ? 14'sd1 : -14'sd1);
            5'd3: tx = {6'd0, job_ff.x} - (job_ff.right_first ? 14'sd1 : -14'sd1);
            default: tx = {6'd0, job_ff.x};
         endcase
      end else begin
         unique case (step_ff)
            5'd1: tx = {6'd0, job_ff.x};
            5'd2: tx = {6'd0, job_ff.x} - 14'sd1;
            5'd3: tx = {6'd0, job_ff.x} + 14'sd1;
            default: begin
               ty = {6'd0, job_ff.y};
               if (step_ff[0]) begin
                  tx = {6'd0, job_ff.x} + {10'd0, 4'((step_ff - 5'd2) >> 1)};
               end else begin
                  tx = {6'd0, job_ff.x} - {10'd0, 4'((step_ff - 5'd2) >> 1)};
               end
            end
         endcase
      end
      cand_ok = (tx >= 0) && (tx < GridWidth) && (ty >= 0) && (ty < GridHeight);
      last_step = (self_ff == CELL_SAND) ? 5'd3 : 5'd3 + {1'b0, side_reach, 1'b0};
   end

   assign raddr = AW'(ty * GridWidth + tx);

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; job_in = job_ff; self_in = self_ff;
      step_in = step_ff; tx_in = tx_ff; ty_in = ty_ff; out_in = out_ff;
      wv1_in = wv1_ff; wv2_in = wv2_ff; ox_in = ox_ff; oy_in = oy_ff; rv_in = rv_ff;
      job_take = 1'b0; mwe = 1'b0; maddr = raddr; mdat = CELL_EMPTY;
      unique case (st_ff)
         ST_CLEAR: begin
            mwe = 1'b1;
            maddr = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(Depth - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               job_in = job;
               step_in = 5'd0;
               self_in = CELL_EMPTY;
               ox_in = job.x;
               oy_in = job.y;
               out_in = OUT_SKIPPED;
               if (job.kind == KIND_SKIP) st_in = ST_OUT;
               else st_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!cand_ok) begin
               if (step_ff == 5'd0) begin
                  out_in = OUT_REFUSED;
                  st_in = ST_OUT;
               end else begin
                  st_in = ST_EVAL;
               end
            end else begin
               tx_in = tx; ty_in = ty;
               st_in = ST_WAIT;
            end
         end
         ST_WAIT: st_in = ST_EVAL;
         ST_EVAL: begin
            st_in = ST_READ;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd0) begin
               self_in = rd_ff;
               if (job_ff.kind == KIND_PLACE) begin
                  if (rd_ff == CELL_EMPTY) begin
                     out_in = OUT_PLACED;
                     wv1_in = job_ff.place_cell;
                     st_in = ST_WR1;
                  end else begin
                     out_in = OUT_REFUSED;
                     st_in = ST_OUT;
                  end
               end else if (rd_ff != CELL_SAND && rd_ff != CELL_WATER) begin
                  st_in = ST_OUT;
               end
            end else begin
               if (cand_ok && rd_ff == CELL_EMPTY) begin
                  out_in = OUT_MOVED;
                  wv1_in = self_ff;
                  wv2_in = CELL_EMPTY;
                  ox_in = tx_ff[7:0]; oy_in = ty_ff[7:0];
                  st_in = ST_WR1;
               end else if (cand_ok && rd_ff == CELL_WATER && self_ff == CELL_SAND) begin
                  out_in = OUT_SWAPPED;
                  wv1_in = CELL_SAND;
                  wv2_in = CELL_WATER;
                  ox_in = tx_ff[7:0]; oy_in = ty_ff[7:0];
                  st_in = ST_WR1;
               end else if (step_ff >= last_step) begin
                  if (self_ff == CELL_SAND) begin
                     out_in = OUT_FROZE;
                     tx_in = {6'd0, job_ff.x}; ty_in = {6'd0, job_ff.y};
                     wv1_in = CELL_FROZEN;
                     st_in = ST_WR1;
                  end else begin
                     out_in = OUT_STAYED;
                     st_in = ST_OUT;
                  end
               end
            end
         end
         ST_WR1: begin
            mwe = 1'b1;
            maddr = AW'(ty_ff * GridWidth + tx_ff);
            mdat = wv1_ff;
            st_in = (out_ff == OUT_MOVED || out_ff == OUT_SWAPPED) ? ST_WR2 : ST_OUT;
         end
         ST_WR2: begin
            mwe = 1'b1;
            maddr = AW'({6'd0, job_ff.y} * GridWidth + {6'd0, job_ff.x});
            mdat = wv2_ff;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (rv_ff && !rsp_stall && !(st_ff == ST_OUT)) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mdat;
      rd_ff <= mem[maddr];
   end

   logic [2:0] ro_ff;
   logic [7:0] rx_ff, ry_ff;
   always_ff @(posedge clock) begin
      if (st_ff == ST_OUT && (!rv_ff || !rsp_stall)) begin
         ro_ff <= out_ff; rx_ff <= ox_ff; ry_ff <= oy_ff;
      end
      job_ff <= job_in; self_ff <= self_in; step_ff <= step_in;
      tx_ff <= tx_in; ty_ff <= ty_in; out_ff <= out_in;
      wv1_ff <= wv1_in; wv2_ff <= wv2_in; ox_ff <= ox_in; oy_ff <= oy_in;
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_outcome = ro_ff;
   assign rsp_new_x = rx_ff;
   assign rsp_new_y = ry_ff;

   `FS_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(st_ff))
   `FS_ASSERT_IMP(a_take_idle, clock, reset, job_take, st_ff == ST_IDLE)
   `FS_ASSERT_NXT(a_wr2_follow, clock, reset, st_ff == ST_WR2, st_ff == ST_OUT)
endmodule

FILE: hdl/falling_sand_cell_update_core.sv
// Falling-sand cell update core: top level with the configuration port.
// One item at a time runs through the back end's single-port grid memory. Each in-grid
// probe passes through the address, memory-read and decide states. After reset a clearing
// pass writes GRID_WIDTH*GRID_HEIGHT cells, one per cycle, before the back end takes
// any job from the front end's queue.
module falling_sand_cell_update_core #(
   parameter int GRID_WIDTH  = fscu_pkg::GridWidthDefault,
   parameter int GRID_HEIGHT = fscu_pkg::GridHeightDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_cell_x,
   input  logic [7:0]  req_cell_y,
   input  logic        req_try_right_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_outcome,
   output logic [7:0]  rsp_new_x,
   output logic [7:0]  rsp_new_y,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fscu_pkg::*;

   logic [2:0] reach_ff;
   logic       job_valid, job_take;
   job_type    job;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CsrSideReach) ? {29'd0, reach_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= SideReachReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CsrSideReach) begin
         reach_ff <= csr_pwdata[2:0];
      end
   end

   fscu_front #(.GridWidth(GRID_WIDTH), .GridHeight(GRID_HEIGHT)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_cell_x,
      .req_cell_y, .req_try_right_first, .job_valid, .job_take, .job
   );

   fscu_back #(.GridWidth(GRID_WIDTH), .GridHeight(GRID_HEIGHT)) u_back (
      .clock, .reset, .side_reach(reach_ff), .job_valid, .job_take, .job,
      .rsp_valid, .rsp_stall, .rsp_outcome, .rsp_new_x, .rsp_new_y
   );
endmodule
